FILE: design/kdb_pkg.sv
// Shared constants, types and helpers for the key debouncer.
// Used by every module of the key debouncer; depends on nothing.
package kdb_pkg;

  localparam int KEY_COUNT  = 3;
  localparam int KEYS_W     = 3;
  localparam int KEY_W      = 2;
  localparam int RING_DEPTH = 8;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  typedef logic [RING_AW-1:0] ring_idx_t;
  typedef logic [TIME_W-1:0]  time_t;

  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_SCAN = 2'd1,
    ACT_POP  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_SCAN_PERIOD = 2'd0,
    REG_DEBOUNCE    = 2'd1,
    REG_LONG_PRESS  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] scan_period_ms;
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic             is_long;
    logic [KEY_W-1:0] key;
  } event_t;

  typedef struct packed {
    logic init;
    logic scan;
  } lane_ctl_t;

  typedef struct packed {
    logic load;
    logic init;
    logic scan;
    logic pop;
  } ring_ctl_t;

  function automatic ring_idx_t ring_inc(input ring_idx_t i);
    ring_idx_t r;
    if (i == RING_AW'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + RING_AW'(1);
    end
    return r;
  endfunction

endpackage

FILE: design/kdb_ifs.sv
// Valid/ready channel interfaces for the key debouncer: request items and event results.
// Depends on nothing.
interface kdb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] now_ms;
  logic [2:0]  keys_pressed;

  modport source(output valid, action, now_ms, keys_pressed, input ready);
  modport sink(input valid, action, now_ms, keys_pressed, output ready);
endinterface

interface kdb_evt_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [1:0] event_key;
  logic       event_long;

  modport source(output valid, event_valid, event_key, event_long, input ready);
  modport sink(input valid, event_valid, event_key, event_long, output ready);
endinterface

FILE: design/kdb_cfg.sv
// APB configuration registers of the key debouncer.
// Depends on kdb_pkg.
module kdb_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kdb_pkg::APB_AW-1:0] paddr,
  input  logic [kdb_pkg::APB_DW-1:0] pwdata,
  output logic [kdb_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output kdb_pkg::cfg_t              cfg
);
  import kdb_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_period_ms <= CFG_W'(10);
      cfg.debounce_ms    <= CFG_W'(20);
      cfg.long_press_ms  <= CFG_W'(1000);
    end else if (wr_en) begin
      unique case (idx)
        REG_SCAN_PERIOD: cfg.scan_period_ms <= pwdata[CFG_W-1:0];
        REG_DEBOUNCE:    cfg.debounce_ms    <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS:  cfg.long_press_ms  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCAN_PERIOD: prdata = APB_DW'(cfg.scan_period_ms);
      REG_DEBOUNCE:    prdata = APB_DW'(cfg.debounce_ms);
      REG_LONG_PRESS:  prdata = APB_DW'(cfg.long_press_ms);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: design/kdb_key_lane.sv
// One key lane: raw and stable levels, debounce and long-press timers.
// Depends on kdb_pkg; decides whether this key pushes an event on a scan.
module kdb_key_lane (
  input  logic               clk,
  input  logic               rst,
  input  kdb_pkg::lane_ctl_t ctl,
  input  kdb_pkg::time_t     now,
  input  logic               level,
  input  kdb_pkg::cfg_t      cfg,
  output logic               push,
  output logic               is_long
);
  import kdb_pkg::*;

  logic  raw, stable, long_done;
  time_t raw_time, press_time;

  logic  raw_chg, st_chg, pressed_now, stable_next, long_done_mid;
  logic  short_push, long_push;
  time_t raw_dt, press_dt;

  always_comb begin
    raw_chg       = level != raw;
    raw_dt        = raw_chg ? '0 : now - raw_time;
    st_chg        = (level != stable) && (raw_dt >= TIME_W'(cfg.debounce_ms));
    stable_next   = st_chg ? level : stable;
    pressed_now   = st_chg && level;
    long_done_mid = pressed_now ? 1'b0 : long_done;
    short_push    = st_chg && !level && !long_done;
    press_dt      = pressed_now ? '0 : now - press_time;
    long_push     = stable_next && !long_done_mid &&
                    (press_dt >= TIME_W'(cfg.long_press_ms));
    push          = ctl.scan && (short_push || long_push);
    is_long       = long_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw        <= 1'b0;
      stable     <= 1'b0;
      long_done  <= 1'b0;
      raw_time   <= '0;
      press_time <= '0;
    end else if (ctl.init) begin
      raw        <= level;
      stable     <= level;
      long_done  <= level;
      raw_time   <= now;
      press_time <= now;
    end else if (ctl.scan) begin
      raw       <= level;
      stable    <= stable_next;
      long_done <= long_done_mid || long_push;
      if (raw_chg) begin
        raw_time <= now;
      end
      if (pressed_now) begin
        press_time <= now;
      end
    end
  end

endmodule

FILE: design/kdb_ring.sv
// Event ring: synchronous event memory with read and write indexes.
// Depends on kdb_pkg; drops the oldest event when a push meets a full ring.
module kdb_ring (
  input  logic                            clk,
  input  logic                            rst,
  input  kdb_pkg::ring_ctl_t              ctl,
  input  logic [kdb_pkg::KEY_COUNT-1:0]   push,
  input  logic [kdb_pkg::KEY_COUNT-1:0]   push_long,
  output logic                            ev_valid,
  output kdb_pkg::event_t                 ev
);
  import kdb_pkg::*;

  event_t    mem [RING_DEPTH];
  ring_idx_t rd, wr, rd_next, wr_next;
  ring_idx_t addr [KEY_COUNT];
  event_t    rdata;

  always_comb begin
    ring_idx_t w;
    ring_idx_t r;
    ring_idx_t n;
    w = wr;
    r = rd;
    for (int k = 0; k < KEY_COUNT; k++) begin
      addr[k] = w;
      n = ring_inc(w);
      if (push[k]) begin
        if (n == r) begin
          r = ring_inc(r);
        end
        w = n;
      end
    end
    rd_next = rd;
    wr_next = wr;
    if (ctl.init) begin
      rd_next = '0;
      wr_next = '0;
    end else if (ctl.scan) begin
      rd_next = r;
      wr_next = w;
    end else if (ctl.pop && (rd != wr)) begin
      rd_next = ring_inc(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd       <= '0;
      wr       <= '0;
      ev_valid <= 1'b0;
    end else if (ctl.load) begin
      rd       <= rd_next;
      wr       <= wr_next;
      ev_valid <= ctl.pop && (rd != wr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rdata <= mem[rd];
    end
    if (ctl.scan) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        if (push[k]) begin
          mem[addr[k]] <= '{is_long: push_long[k], key: KEY_W'(k)};
        end
      end
    end
  end

  assign ev = ev_valid ? rdata : '0;

endmodule

FILE: design/key_debounce_short_long_press.sv
// Key debouncer with short and long press events held in an eight-slot ring.
// Depends on kdb_pkg, kdb_ifs, kdb_cfg, kdb_key_lane and kdb_ring.
//
// The req channel carries one item per transfer: an init sample, a scan or a
// pop, with a millisecond time and the raw levels of three keys. The evt
// channel returns exactly one result per item; only a pop of a non-empty ring
// sets event_valid, all other results are zero. The APB port holds the scan
// period, debounce time and long-press time; the user must write it only
// while idle, which the block itself does not enforce. Each item is processed
// on the edge of its transfer and its result sits in the output register from
// the next cycle; a new item can be taken every cycle unless the receiver
// stalls. The three key lanes work in parallel and the ring memory takes every
// push of a scan together; the pop reads the memory into the output register.
// While the receiver stalls, the result is held and req.ready stays low
// until the result is taken; a transfer in the cycle the result leaves is
// taken at once.
// Reset clears all key state, empties the ring and loads the register
// defaults of 10, 20 and 1000 ms.
module key_debounce_short_long_press (
  input  logic                       clk,
  input  logic                       rst,
  kdb_req_if.sink                    req,
  kdb_evt_if.source                  evt,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kdb_pkg::APB_AW-1:0] paddr,
  input  logic [kdb_pkg::APB_DW-1:0] pwdata,
  output logic [kdb_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import kdb_pkg::*;

  cfg_t                 cfg;
  time_t                last_scan;
  logic                 out_valid;
  logic                 acc, scan_ok;
  lane_ctl_t            lane_ctl;
  ring_ctl_t            ring_ctl;
  logic [KEY_COUNT-1:0] lvl, push, push_long;
  logic                 ev_valid;
  event_t               ev;

  kdb_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign req.ready = !out_valid || evt.ready;
  assign acc       = req.valid && req.ready;
  assign scan_ok   = (req.now_ms - last_scan) >= TIME_W'(cfg.scan_period_ms);

  always_comb begin
    lane_ctl.init = acc && (req.action == ACT_INIT);
    lane_ctl.scan = acc && (req.action == ACT_SCAN) && scan_ok;
    ring_ctl.load = acc;
    ring_ctl.init = lane_ctl.init;
    ring_ctl.scan = lane_ctl.scan;
    ring_ctl.pop  = acc && (req.action == ACT_POP);
  end

  for (genvar g = 0; g < KEY_COUNT; g++) begin : g_lane
    if (g < KEYS_W) begin : g_in
      assign lvl[g] = req.keys_pressed[g];
    end else begin : g_none
      assign lvl[g] = 1'b0;
    end

    kdb_key_lane u_lane (
      .clk(clk), .rst(rst), .ctl(lane_ctl), .now(req.now_ms), .level(lvl[g]),
      .cfg(cfg), .push(push[g]), .is_long(push_long[g])
    );
  end

  kdb_ring u_ring (
    .clk(clk), .rst(rst), .ctl(ring_ctl), .push(push), .push_long(push_long),
    .ev_valid(ev_valid), .ev(ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_scan <= '0;
      out_valid <= 1'b0;
    end else begin
      if (lane_ctl.init || lane_ctl.scan) begin
        last_scan <= req.now_ms;
      end
      if (acc) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign evt.valid       = out_valid;
  assign evt.event_valid = ev_valid;
  assign evt.event_key   = ev.key;
  assign evt.event_long  = ev.is_long;

endmodule
